// ----- design/rbds_pkg.sv -----
// Package for the stepped backoff retry timer.
// Holds command codes, step and register constants, and the beat payload types.
// No dependencies.
package rbds_pkg;

  localparam int BACKOFF_STEPS  = 5;
  localparam int NUM_DELAY_REGS = 5;
  localparam int STEP_W         = 3;
  localparam int DELAY_W        = 16;
  localparam int TIME_W         = 32;
  localparam int GEN_W          = 32;
  localparam int FUNC_W         = 3;
  localparam int CFG_IDX_W      = 3;

  localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RETARGET = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TAKE_DUE = 3'd4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BACKOFF_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_REG  = STEP_W'(NUM_DELAY_REGS - 1);

  localparam logic [DELAY_W-1:0] DELAY_RESET [NUM_DELAY_REGS] =
    '{16'd1000, 16'd2000, 16'd5000, 16'd10000, 16'd30000};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_time;
    logic [GEN_W-1:0]  conn_gen;
    logic              display_on;
  } cmd_item_t;

  typedef struct packed {
    logic              accepted;
    logic              armed;
    logic [TIME_W-1:0] due_time;
  } res_item_t;

  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] idx);
    return (idx < LAST_STEP) ? idx : LAST_STEP;
  endfunction

  function automatic logic [STEP_W-1:0] clamp_reg(input logic [STEP_W-1:0] idx);
    return (idx < LAST_REG) ? idx : LAST_REG;
  endfunction

endpackage

// ----- design/rbds_cmd_if.sv -----
// Command channel of the backoff retry timer: valid/ready with one command per beat.
// Depends on rbds_pkg for the payload type.
interface rbds_cmd_if import rbds_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/rbds_res_if.sv -----
// Result channel of the backoff retry timer: valid/ready with one result per beat.
// Depends on rbds_pkg for the payload type.
interface rbds_res_if import rbds_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/reconnect_backoff_deadline_scheduler.sv -----
// Stepped backoff retry timer: one pending retry deadline driven by commands.
// Depends on rbds_pkg, rbds_cmd_if and rbds_res_if.
//
// Usage:
//   cmd  - command beats (reset, schedule, retarget, cancel, take-due) with the
//          current ms time, the link generation and the display state.
//   res  - one result beat per command: accepted flag, armed flag and the
//          armed deadline (0 while idle).
//   cfg_* - write port for the five 16-bit backoff delays, index 0 to 4;
//          writes to other indexes are dropped. Write only while idle.
// Throughput: one command per cycle while not stalled. The state update
//   (table pick, one 32-bit add, one wrapping compare) finishes in the accept
//   cycle and the result sits in a single output register.
// Stall: cmd.ready stays high while the output register is empty or being
//   drained in the same cycle; when the receiver holds res.ready low with a
//   result waiting, cmd.ready drops and the result holds.
// Reset (rst, synchronous): clears the pending deadline, the step counter and
//   the res_valid flag, and reloads the delays with 1000/2000/5000/10000/30000.
module reconnect_backoff_deadline_scheduler import rbds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rbds_cmd_if.sink             cmd,
  rbds_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data
);

  // Backoff delay registers
  logic [DELAY_W-1:0] delay_reg [NUM_DELAY_REGS];

  // Deadline state
  logic              pending_flag,     pending_flag_next;
  logic              armed_screen_on,  armed_screen_on_next;
  logic [STEP_W-1:0] armed_step,       armed_step_next;
  logic [STEP_W-1:0] next_step,        next_step_next;
  logic [TIME_W-1:0] deadline_time,    deadline_time_next;
  logic [GEN_W-1:0]  armed_generation, armed_generation_next;

  // Output register
  logic      res_valid;
  res_item_t res_data;
  logic      acc;

  logic              cmd_fire;
  logic [STEP_W-1:0] sel_step;
  logic [STEP_W-1:0] sel_reg;
  logic [TIME_W-1:0] new_deadline;
  logic [TIME_W-1:0] due_diff;
  logic              gen_match;

  assign cmd.ready   = !res_valid || res.ready;
  assign cmd_fire    = cmd.valid && cmd.ready;
  assign res.valid   = res_valid;
  assign res.payload = res_data;

  // Config writes: drop indexes past the delay list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DELAY_REGS; i++) begin
        delay_reg[i] <= DELAY_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_DELAY_REGS))) begin
      delay_reg[cfg_index] <= cfg_data;
    end
  end

  // One shared add: schedule uses the next step, retarget the armed step
  always_comb begin
    sel_step     = (cmd.payload.func == FUNC_SCHEDULE) ? clamp_step(next_step)
                                                       : clamp_step(armed_step);
    sel_reg      = clamp_reg(sel_step);
    new_deadline = cmd.payload.now_time + TIME_W'(delay_reg[sel_reg]);
    due_diff     = cmd.payload.now_time - deadline_time;
    gen_match    = (cmd.payload.conn_gen != '0) &&
                   (cmd.payload.conn_gen == armed_generation);
  end

  always_comb begin
    pending_flag_next     = pending_flag;
    armed_screen_on_next  = armed_screen_on;
    armed_step_next       = armed_step;
    next_step_next        = next_step;
    deadline_time_next    = deadline_time;
    armed_generation_next = armed_generation;
    acc                   = 1'b0;
    // disarm is the common tail of several commands
    case (cmd.payload.func)
      FUNC_RESET: begin
        pending_flag_next     = 1'b0;
        armed_screen_on_next  = 1'b0;
        armed_step_next       = '0;
        deadline_time_next    = '0;
        armed_generation_next = '0;
        next_step_next        = '0;
      end
      FUNC_SCHEDULE: begin
        if (cmd.payload.conn_gen != '0) begin
          if (!cmd.payload.display_on) begin
            pending_flag_next     = 1'b0;
            armed_screen_on_next  = 1'b0;
            armed_step_next       = '0;
            deadline_time_next    = '0;
            armed_generation_next = '0;
          end else begin
            armed_step_next       = sel_step;
            armed_screen_on_next  = 1'b1;
            deadline_time_next    = new_deadline;
            armed_generation_next = cmd.payload.conn_gen;
            pending_flag_next     = 1'b1;
            if (next_step < LAST_STEP) begin
              next_step_next = next_step + 1'b1;
            end
          end
        end
      end
      FUNC_RETARGET: begin
        if (pending_flag) begin
          if (!cmd.payload.display_on) begin
            pending_flag_next     = 1'b0;
            armed_screen_on_next  = 1'b0;
            armed_step_next       = '0;
            deadline_time_next    = '0;
            armed_generation_next = '0;
            acc                   = 1'b1;
          end else if (!armed_screen_on) begin
            armed_step_next      = sel_step;
            armed_screen_on_next = 1'b1;
            deadline_time_next   = new_deadline;
            acc                  = 1'b1;
          end
        end
      end
      FUNC_CANCEL: begin
        pending_flag_next     = 1'b0;
        armed_screen_on_next  = 1'b0;
        armed_step_next       = '0;
        deadline_time_next    = '0;
        armed_generation_next = '0;
      end
      FUNC_TAKE_DUE: begin
        // fire when the wrapping difference is non-negative
        if (pending_flag && gen_match && !due_diff[TIME_W-1]) begin
          pending_flag_next     = 1'b0;
          armed_screen_on_next  = 1'b0;
          armed_step_next       = '0;
          deadline_time_next    = '0;
          armed_generation_next = '0;
          acc                   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag     <= 1'b0;
      armed_screen_on  <= 1'b0;
      armed_step       <= '0;
      next_step        <= '0;
      deadline_time    <= '0;
      armed_generation <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (cmd_fire) begin
        pending_flag     <= pending_flag_next;
        armed_screen_on  <= armed_screen_on_next;
        armed_step       <= armed_step_next;
        next_step        <= next_step_next;
        deadline_time    <= deadline_time_next;
        armed_generation <= armed_generation_next;
        res_valid        <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_data.accepted <= acc;
      res_data.armed    <= pending_flag_next;
      res_data.due_time <= deadline_time_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !pending_flag |-> (deadline_time == '0) && (armed_generation == '0) && !armed_screen_on)
    else $error("idle timer holds a stale deadline or generation");

  a_armed_gen: assert property (@(posedge clk) disable iff (rst)
    pending_flag |-> (armed_generation != '0))
    else $error("armed timer has an invalid generation");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (next_step <= LAST_STEP) && (armed_step <= LAST_STEP))
    else $error("backoff step beyond last step");

  a_reset_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && (cmd.payload.func == FUNC_RESET)
      |=> !pending_flag && (next_step == '0) && res_valid && !res_data.accepted)
    else $error("reset command did not clear the timer");
`endif

endmodule

// ----- test/reconnect_backoff_deadline_scheduler_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for reconnect_backoff_deadline_scheduler: random and directed commands,
// checked beat by beat against an in-bench model of the backoff timer.
// Depends on rbds_pkg, rbds_cmd_if, rbds_res_if and the scheduler itself.
module reconnect_backoff_deadline_scheduler_test;
  import rbds_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 170;
  localparam int IDLE_PERCENT   = 26;
  localparam int STEADY_LO      = 300;   // beats in [STEADY_LO, STEADY_HI) never idle
  localparam int STEADY_HI      = 420;
  localparam int LONG_STALL     = 150;
  localparam int STALL_AT_A     = 120;
  localparam int STALL_AT_B     = 600;
  localparam int DRAIN_CYCLES   = 4;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_TAKE_DUE + 1'b1;
  localparam int CFG_IDX_TOP    = (1 << CFG_IDX_W) - 1;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELAY_W-1:0]   cfg_data;

  rbds_cmd_if cmd_if ();
  rbds_res_if res_if ();

  reconnect_backoff_deadline_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the retry timer: one pending deadline plus the backoff step counter.
  logic                tmr_pending;
  logic                tmr_armed_on;
  logic [STEP_W-1:0]   tmr_step;
  logic [STEP_W-1:0]   tmr_next_step;
  logic [TIME_W-1:0]   tmr_deadline;
  logic [GEN_W-1:0]    tmr_gen;
  logic [DELAY_W-1:0]  step_wait  [NUM_DELAY_REGS];
  logic [DELAY_W-1:0]  delay_plan [NUM_DELAY_REGS];

  cmd_item_t cmd_backlog[$];       // commands waiting for the driver
  res_item_t deadline_reports[$];  // predicted result beats, oldest first

  // Random session: the generation and time base that take-due beats aim at.
  logic [GEN_W-1:0]  sess_gen;
  logic [TIME_W-1:0] sess_now;
  int unsigned       sess_reach;

  int cmds_sent;
  int results_seen;
  int stall_left;
  int fault_count;
  int fired_count;
  int retarget_hits;
  int settings_loaded;
  int cycle_count;

  function automatic logic [STEP_W-1:0] step_clamp(input logic [STEP_W-1:0] idx);
    return (int'(idx) < BACKOFF_STEPS) ? idx : STEP_W'(BACKOFF_STEPS - 1);
  endfunction

  function automatic logic [TIME_W-1:0] step_delay_ms(input logic [STEP_W-1:0] idx);
    return TIME_W'(step_wait[(int'(idx) < NUM_DELAY_REGS) ? int'(idx) : NUM_DELAY_REGS - 1]);
  endfunction

  function automatic void disarm_timer();
    tmr_pending  = 1'b0;
    tmr_armed_on = 1'b0;
    tmr_step     = '0;
    tmr_deadline = '0;
    tmr_gen      = '0;
  endfunction

  // Advance the timer model by one command and return the beat it must produce.
  function automatic res_item_t apply_timer_cmd(input cmd_item_t c);
    res_item_t         r;
    logic [STEP_W-1:0] pick;
    logic [TIME_W-1:0] lag;
    r.accepted = 1'b0;
    case (c.func)
      FUNC_RESET: begin
        disarm_timer();
        tmr_next_step = '0;
      end
      FUNC_SCHEDULE: begin
        // A zero generation leaves everything alone; display off acts as cancel.
        if (c.conn_gen != '0) begin
          if (!c.display_on) begin
            disarm_timer();
          end else begin
            pick          = step_clamp(tmr_next_step);
            tmr_step      = pick;
            tmr_armed_on  = 1'b1;
            tmr_deadline  = c.now_time + step_delay_ms(pick);
            tmr_gen       = c.conn_gen;
            tmr_pending   = 1'b1;
            if (int'(tmr_next_step) + 1 < BACKOFF_STEPS) tmr_next_step = tmr_next_step + 1'b1;
          end
        end
      end
      FUNC_RETARGET: begin
        if (tmr_pending) begin
          if (!c.display_on) begin
            disarm_timer();
            r.accepted = 1'b1;
          end else if (!tmr_armed_on) begin
            tmr_step     = step_clamp(tmr_step);
            tmr_armed_on = 1'b1;
            tmr_deadline = c.now_time + step_delay_ms(tmr_step);
            r.accepted   = 1'b1;
          end
        end
        if (r.accepted) retarget_hits++;
      end
      FUNC_CANCEL: begin
        disarm_timer();
      end
      FUNC_TAKE_DUE: begin
        // Due when the wrapping difference now - deadline has its sign bit clear.
        lag = c.now_time - tmr_deadline;
        if (tmr_pending && c.conn_gen != '0 && c.conn_gen == tmr_gen &&
            !lag[TIME_W-1]) begin
          disarm_timer();
          r.accepted = 1'b1;
          fired_count++;
        end
      end
      default: ;
    endcase
    r.armed    = tmr_pending;
    r.due_time = tmr_deadline;
    return r;
  endfunction

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] now_time,
                           input logic [GEN_W-1:0] gen, input logic display_on);
    cmd_item_t c;
    c.func       = func;
    c.now_time   = now_time;
    c.conn_gen   = gen;
    c.display_on = display_on;
    cmd_backlog.push_back(c);
  endtask

  // Mostly schedule / take-due sessions around a moving time base, with noise mixed in.
  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int        roll;
    c.func       = FUNC_CANCEL;
    c.now_time   = $urandom;
    c.conn_gen   = $urandom;
    c.display_on = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      c.func = FUNC_RESET;
    end else if (roll < 30) begin
      c.func = FUNC_SCHEDULE;
      if ($urandom_range(0, 3) == 0)
        sess_gen = ($urandom_range(0, 19) == 0) ? '0 : GEN_W'($urandom);
      if ($urandom_range(0, 4) == 0) sess_now = $urandom;
      else sess_now = sess_now + $urandom_range(0, sess_reach);
      c.now_time   = sess_now;
      c.conn_gen   = sess_gen;
      c.display_on = ($urandom_range(0, 99) < 85);
    end else if (roll < 40) begin
      c.func = FUNC_RETARGET;
    end else if (roll < 47) begin
      c.func = FUNC_CANCEL;
    end else if (roll < 96) begin
      c.func = FUNC_TAKE_DUE;
      case ($urandom_range(0, 9))
        0:       ;  // keep the fully random time
        1:       c.now_time = sess_now - $urandom_range(1, sess_reach);
        default: c.now_time = sess_now + $urandom_range(0, sess_reach);
      endcase
      if ($urandom_range(0, 9) < 8) c.conn_gen = sess_gen;
      else if ($urandom_range(0, 1) == 0) c.conn_gen = '0;
    end else begin
      c.func = FUNC_SPARE_LO + FUNC_W'($urandom_range(0, CFG_IDX_TOP - int'(FUNC_SPARE_LO)));
    end
    return c;
  endfunction

  // Hold until the backlog is empty, nothing is offered and every beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_if.valid || deadline_reports.size() != 0)
      @(negedge clk);
  endtask

  // Write delay_plan into the five registers, then one write to an index past the list.
  task automatic load_delays();
    for (int i = 0; i < NUM_DELAY_REGS; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= delay_plan[i];
      step_wait[i] = delay_plan[i];
    end
    @(posedge clk);
    cfg_index <= CFG_IDX_W'($urandom_range(NUM_DELAY_REGS, CFG_IDX_TOP));
    cfg_data  <= DELAY_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Driver: record the accepted beat in the model, then offer the next command.
  // Valid never drops while a beat is waiting; idling only happens between beats.
  always @(posedge clk) begin
    bit idle;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        deadline_reports.push_back(apply_timer_cmd(cmd_if.payload));
        cmds_sent++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        idle = (cmds_sent < STEADY_LO || cmds_sent >= STEADY_HI) &&
               ($urandom_range(0, 99) < IDLE_PERCENT);
        if (!idle && cmd_backlog.size() != 0) begin
          cmd_if.payload <= cmd_backlog.pop_front();
          cmd_if.valid   <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction and pace res.ready.
  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (deadline_reports.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result beat, expected none, actual %p", $time,
                   res_if.payload);
        end else begin
          want = deadline_reports.pop_front();
          if (res_if.payload.accepted !== want.accepted) begin
            fault_count++;
            $display("%0t: accepted mismatch, expected %0b, actual %0b", $time,
                     want.accepted, res_if.payload.accepted);
          end
          if (res_if.payload.armed !== want.armed) begin
            fault_count++;
            $display("%0t: armed mismatch, expected %0b, actual %0b", $time,
                     want.armed, res_if.payload.armed);
          end
          if (res_if.payload.due_time !== want.due_time) begin
            fault_count++;
            $display("%0t: due_time mismatch, expected %0d, actual %0d", $time,
                     want.due_time, res_if.payload.due_time);
          end
        end
        // Hold ready low for a long stretch so the block backs up into cmd.ready.
        if (results_seen == STALL_AT_A || results_seen == STALL_AT_B) stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (results_seen >= STEADY_LO && results_seen < STEADY_HI) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: end the run if the traffic stops moving.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats still expected", $time,
               cycle_count, deadline_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned widest;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    res_if.ready   = 1'b0;
    cmds_sent       = 0;
    results_seen    = 0;
    stall_left      = 0;
    fault_count     = 0;
    fired_count     = 0;
    retarget_hits   = 0;
    settings_loaded = 0;
    cycle_count     = 0;
    sess_gen   = 32'h1;
    sess_now   = '0;
    sess_reach = 40000;
    // Power-on delays of the block.
    step_wait[0] = 16'd1000;
    step_wait[1] = 16'd2000;
    step_wait[2] = 16'd5000;
    step_wait[3] = 16'd10000;
    step_wait[4] = 16'd30000;
    disarm_timer();
    tmr_next_step = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed sweep on the power-on delays.
    queue_cmd(FUNC_RESET,    32'h0,          32'h0,          1'b1);
    queue_cmd(FUNC_RETARGET, 32'h10,         32'h5,          1'b1);  // retarget while idle
    queue_cmd(FUNC_TAKE_DUE, 32'h10,         32'h5,          1'b1);  // take-due while idle
    queue_cmd(FUNC_SCHEDULE, 32'h20,         32'h0,          1'b1);  // zero generation
    queue_cmd(FUNC_SCHEDULE, 32'h20,         32'h7,          1'b0);  // display off cancels
    queue_cmd(FUNC_SCHEDULE, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);  // deadline sum wraps
    queue_cmd(FUNC_TAKE_DUE, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);  // not yet due across wrap
    queue_cmd(FUNC_TAKE_DUE, 32'd999,        32'hFFFF_FFFE,  1'b1);  // wrong generation
    queue_cmd(FUNC_TAKE_DUE, 32'd999,        32'h0,          1'b1);  // zero generation
    queue_cmd(FUNC_RETARGET, 32'd500,        32'h0,          1'b1);  // armed with display on
    queue_cmd(FUNC_TAKE_DUE, 32'd999,        32'hFFFF_FFFF,  1'b1);  // exactly at the deadline
    queue_cmd(FUNC_SCHEDULE, 32'h0,          32'h1,          1'b1);
    queue_cmd(FUNC_TAKE_DUE, 32'h8000_07CF,  32'h1,          1'b1);  // largest positive lag
    queue_cmd(FUNC_SCHEDULE, 32'h0,          32'h1,          1'b1);
    queue_cmd(FUNC_TAKE_DUE, 32'h8000_1388,  32'h1,          1'b1);  // lag with sign bit set
    queue_cmd(FUNC_RETARGET, 32'h0,          32'h1,          1'b0);  // display off cancels
    queue_cmd(FUNC_SCHEDULE, 32'h1234_5678,  32'h2,          1'b1);
    queue_cmd(FUNC_CANCEL,   32'h0,          32'h2,          1'b1);  // step counter survives
    queue_cmd(FUNC_SCHEDULE, 32'h7FFF_FFFF,  32'h3,          1'b1);  // last step
    queue_cmd(FUNC_SCHEDULE, 32'h8000_0000,  32'h3,          1'b1);  // step saturates
    queue_cmd(FUNC_SPARE_LO,        32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    queue_cmd(FUNC_SPARE_LO + 3'd1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    queue_cmd(FUNC_SPARE_LO + 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(FUNC_RESET,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);  // clears the step counter
    queue_cmd(FUNC_SCHEDULE, 32'd100,        32'h9,          1'b1);
    wait_drained();

    // Random phases, each on its own delay setting; the block is drained before every load.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      widest = 0;
      for (int i = 0; i < NUM_DELAY_REGS; i++) begin
        case (phase)
          0:       delay_plan[i] = DELAY_W'($urandom_range(0, 16'hFFFF));
          1:       delay_plan[i] = '0;
          2:       delay_plan[i] = '1;
          3:       delay_plan[i] = DELAY_W'($urandom_range(0, 4));
          default: delay_plan[i] = ($urandom_range(0, 2) == 0) ? '0 :
                                   ($urandom_range(0, 1) == 0) ? '1 :
                                   DELAY_W'($urandom_range(1, 16'hFFFE));
        endcase
        if (32'(delay_plan[i]) > widest) widest = 32'(delay_plan[i]);
      end
      load_delays();
      sess_reach = widest + 64;
      for (int n = 0; n < PHASE_ITEMS; n++) cmd_backlog.push_back(random_cmd());
      wait_drained();
    end

    // Let any stray beat surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d commands over %0d delay settings: %0d deadlines fired,",
             cmds_sent, settings_loaded, fired_count);
    $display("%0d retargets took effect, %0d result beats checked, %0d mismatches.",
             retarget_hits, results_seen, fault_count);
    if (fault_count == 0 && deadline_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
